// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the checker file of the sorted priority queue.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, held off while rst_n is low.
`define SPQ_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, sampled on clk, held off while rst_n is low.
`define SPQ_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/core/spq_pkg.sv =====
// Package with widths, codes and shared types of the sorted priority queue.
`default_nettype none

package spq_pkg;

    localparam int CAPACITY_DEF    = 64;
    localparam int VALUE_WIDTH_DEF = 32;

    localparam int ACTION_W = 2;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;
    localparam int POS_W    = 6;
    localparam int COUNT_W  = 7;

    localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_REMOVE = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_FIND   = 2'd2;

    localparam logic [STATUS_W-1:0] STAT_DONE      = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd2;

    typedef struct packed {
        logic valid;
        logic ge;
        logic eq;
    } spq_flags_t;

    typedef struct packed {
        logic ins;
        logic rm;
    } spq_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/core/spq_req_if.sv =====
// Request channel interface: action and value with a valid/ready handshake.
`default_nettype none

interface spq_req_if
    import spq_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic [ACTION_W-1:0]       action;
    logic signed [DATA_W-1:0]  value;

    modport source (output valid, output action, output value, input ready);
    modport sink (input valid, input action, input value, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/spq_rsp_if.sv =====
// Response channel interface: status, position, head, count and empty flag.
`default_nettype none

interface spq_rsp_if
    import spq_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic [STATUS_W-1:0]       status;
    logic [POS_W-1:0]          position;
    logic signed [DATA_W-1:0]  head_value;
    logic [COUNT_W-1:0]        entry_count;
    logic                      is_empty;

    modport source (output valid, output status, output position, output head_value,
                    output entry_count, output is_empty, input ready);
    modport sink (input valid, input status, input position, input head_value,
                  input entry_count, input is_empty, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/sorted_priority_queue.sv =====
// Top level of the sorted priority queue built from a chain of compare-and-shift cells.
// A request transfer is captured into the action and key registers; in the execute step all
// cells compare and shift together and the response register is loaded, but execute waits
// while a pending response has not been taken. No new request is taken until execute ends.
// A pending response does not hold off the next request transfer.
// Reset: the store is empty, no response is pending and the request side is ready.
`default_nettype none

module sorted_priority_queue
    import spq_pkg::*;
#(
    parameter int CAPACITY    = CAPACITY_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    spq_req_if.sink   req,
    spq_rsp_if.source rsp
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    state_t                        state_reg;
    state_t                        state_next;
    logic [ACTION_W-1:0]           action_reg;
    logic signed [VALUE_WIDTH-1:0] key_reg;
    logic [CNT_W-1:0]              count_reg;
    logic [CNT_W-1:0]              count_next;

    logic                          rsp_valid_reg;
    logic [STATUS_W-1:0]           rsp_status_reg;
    logic [POS_W-1:0]              rsp_position_reg;
    logic signed [DATA_W-1:0]      rsp_head_reg;
    logic [COUNT_W-1:0]            rsp_count_reg;
    logic                          rsp_empty_reg;

    logic                          exec_go;
    logic                          full;
    logic                          found;
    logic [IDX_W-1:0]              ins_pos;
    logic [IDX_W-1:0]              eq_pos;
    logic [IDX_W-1:0]              op_pos;
    logic [STATUS_W-1:0]           op_status;
    spq_cmd_t                      cmd;

    spq_flags_t                    cell_flags [CAPACITY];
    logic signed [VALUE_WIDTH-1:0] cell_value [CAPACITY];
    logic signed [VALUE_WIDTH-1:0] cell_value_next [CAPACITY];
    logic [CAPACITY-1:0]           ins_hit;
    logic [CAPACITY-1:0]           first_eq;

    assign req.ready = (state_reg == ST_IDLE);
    assign exec_go   = (state_reg == ST_EXEC) && (!rsp_valid_reg || rsp.ready);
    assign full      = (count_reg == CNT_W'(CAPACITY));
    assign found     = |first_eq;

    assign cmd.ins = exec_go && (action_reg == ACT_INSERT) && !full;
    assign cmd.rm  = exec_go && (action_reg == ACT_REMOVE) && found;

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        spq_flags_t                    left_flags;
        spq_flags_t                    right_flags;
        logic signed [VALUE_WIDTH-1:0] left_value;
        logic signed [VALUE_WIDTH-1:0] right_value;

        if (i == 0)
        begin : g_first
            assign left_flags = '{valid: 1'b1, ge: 1'b0, eq: 1'b0};
            assign left_value = '0;
        end
        else
        begin : g_mid_left
            assign left_flags = cell_flags[i-1];
            assign left_value = cell_value[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_flags = '{valid: 1'b0, ge: 1'b0, eq: 1'b0};
            assign right_value = '0;
        end
        else
        begin : g_mid_right
            assign right_flags = cell_flags[i+1];
            assign right_value = cell_value[i+1];
        end

        spq_cell #(
            .VALUE_WIDTH (VALUE_WIDTH)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .cmd         (cmd),
            .key         (key_reg),
            .left_flags  (left_flags),
            .left_value  (left_value),
            .right_flags (right_flags),
            .right_value (right_value),
            .flags       (cell_flags[i]),
            .value       (cell_value[i]),
            .value_next  (cell_value_next[i]),
            .ins_hit     (ins_hit[i]),
            .first_eq    (first_eq[i])
        );
    end

    // At most one cell raises each hit, so an OR over the tagged indices
    // gives its position.
    always_comb
    begin
        ins_pos = '0;
        eq_pos  = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (ins_hit[i])
            begin
                ins_pos = ins_pos | IDX_W'(i);
            end
            if (first_eq[i])
            begin
                eq_pos = eq_pos | IDX_W'(i);
            end
        end
    end

    always_comb
    begin
        op_status = STAT_NOT_FOUND;
        op_pos    = '0;
        unique case (action_reg) inside
            ACT_INSERT:
            begin
                if (full)
                begin
                    op_status = STAT_FULL;
                end
                else
                begin
                    op_status = STAT_DONE;
                    op_pos    = ins_pos;
                end
            end
            ACT_REMOVE, ACT_FIND:
            begin
                if (found)
                begin
                    op_status = STAT_DONE;
                    op_pos    = eq_pos;
                end
            end
            default:
            begin
                op_status = STAT_NOT_FOUND;
            end
        endcase
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.ins)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (cmd.rm)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (exec_go)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (exec_go)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            action_reg <= req.action;
            key_reg    <= VALUE_WIDTH'(req.value);
        end
        if (exec_go)
        begin
            rsp_status_reg   <= op_status;
            rsp_position_reg <= POS_W'(op_pos);
            rsp_head_reg     <= (count_next != '0) ? DATA_W'(cell_value_next[0]) : '0;
            rsp_count_reg    <= COUNT_W'(count_next);
            rsp_empty_reg    <= (count_next == '0);
        end
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.status      = rsp_status_reg;
    assign rsp.position    = rsp_position_reg;
    assign rsp.head_value  = rsp_head_reg;
    assign rsp.entry_count = rsp_count_reg;
    assign rsp.is_empty    = rsp_empty_reg;

endmodule

`default_nettype wire

// ===== rtl/core/spq_cell.sv =====
// One storage cell of the sorted chain: compares against the key and shifts.
`default_nettype none

module spq_cell
    import spq_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire spq_cmd_t                      cmd,
    input  wire logic signed [VALUE_WIDTH-1:0] key,
    input  wire spq_flags_t                    left_flags,
    input  wire logic signed [VALUE_WIDTH-1:0] left_value,
    input  wire spq_flags_t                    right_flags,
    input  wire logic signed [VALUE_WIDTH-1:0] right_value,
    output spq_flags_t                         flags,
    output logic signed [VALUE_WIDTH-1:0]      value,
    output logic signed [VALUE_WIDTH-1:0]      value_next,
    output logic                               ins_hit,
    output logic                               first_eq
);

    logic                          valid_reg;
    logic                          valid_next;
    logic signed [VALUE_WIDTH-1:0] value_reg;

    assign flags.valid = valid_reg;
    assign flags.ge    = valid_reg && (value_reg >= key);
    assign flags.eq    = valid_reg && (value_reg == key);
    assign value       = value_reg;

    // The new entry lands in the first cell that is at least the key, or in
    // the first free cell when no stored entry is.
    assign ins_hit  = left_flags.valid && !left_flags.ge && (flags.ge || !valid_reg);
    assign first_eq = flags.eq && !left_flags.eq;

    always_comb
    begin
        value_next = value_reg;
        valid_next = valid_reg;
        if (cmd.ins)
        begin
            if (left_flags.ge)
            begin
                value_next = left_value;
                valid_next = left_flags.valid;
            end
            else if (ins_hit)
            begin
                value_next = key;
                valid_next = 1'b1;
            end
        end
        else if (cmd.rm)
        begin
            if (flags.ge)
            begin
                value_next = right_value;
                valid_next = right_flags.valid;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule

`default_nettype wire

// ===== rtl/core/spq_checker.sv =====
// Port-level checker for the sorted priority queue, bound to the top level.
`default_nettype none

`include "assert_macros.svh"

module spq_checker
    import spq_pkg::*;
(
    input wire logic                     clk,
    input wire logic                     rst_n,
    input wire logic                     req_valid,
    input wire logic                     req_ready,
    input wire logic                     rsp_valid,
    input wire logic                     rsp_ready,
    input wire logic [STATUS_W-1:0]      rsp_status,
    input wire logic [POS_W-1:0]         rsp_position,
    input wire logic signed [DATA_W-1:0] rsp_head_value,
    input wire logic [COUNT_W-1:0]       rsp_entry_count,
    input wire logic                     rsp_is_empty
);

    `SPQ_ASSERT_NOW(a_empty_matches_count, rsp_valid, rsp_is_empty == (rsp_entry_count == '0))
    `SPQ_ASSERT_NOW(a_empty_head_zero, rsp_valid && rsp_is_empty, rsp_head_value == '0)
    `SPQ_ASSERT_NOW(a_miss_position_zero, rsp_valid && (rsp_status != STAT_DONE), rsp_position == '0)
    `SPQ_ASSERT_NEXT(a_one_at_a_time, req_valid && req_ready, !req_ready)
    `SPQ_ASSERT_NEXT(a_rsp_held, rsp_valid && !rsp_ready, rsp_valid)

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_valid       (req.valid),
    .req_ready       (req.ready),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_status      (rsp.status),
    .rsp_position    (rsp.position),
    .rsp_head_value  (rsp.head_value),
    .rsp_entry_count (rsp.entry_count),
    .rsp_is_empty    (rsp.is_empty)
);

`default_nettype wire
